>>> rtl/core/gls_pkg.sv
// Shared constants for the GCD / LCM unit.
package gls_pkg;

  // Default operand width; results follow from it.
  localparam int unsigned OPERAND_WIDTH_DEF = 16;

endpackage : gls_pkg

>>> rtl/core/gls_engine.sv
// Sequencer with one shared subtractor: binary GCD, restoring divide, then one multiply.
module gls_engine #(
  parameter int unsigned OPERAND_WIDTH = gls_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_valid,
  output logic                       start_ready,
  input  logic [OPERAND_WIDTH-1:0]   first_value,
  input  logic [OPERAND_WIDTH-1:0]   second_value,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [OPERAND_WIDTH-1:0]   gcd_value,
  output logic [2*OPERAND_WIDTH-1:0] lcm_value,
  output logic                       error_flag
);
  import gls_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  state_t            state_r;
  logic [W-1:0]      a_r;
  logic [W-1:0]      b_r;
  logic [W-1:0]      u_r;
  logic [W-1:0]      v_r;
  logic [CW-1:0]     k_r;
  logic [W-1:0]      g_r;
  logic [W-1:0]      rem_r;
  logic [W-1:0]      quo_r;
  logic [CW-1:0]     cnt_r;
  logic [2*W-1:0]    lcm_r;
  logic              err_r;

  // Shared subtractor
  logic [W:0] sub_x;
  logic [W:0] sub_y;
  logic [W:0] sub_d;
  logic       sub_borrow;

  always_comb begin
    if (state_r == ST_DIV) begin
      sub_x = {rem_r, quo_r[W-1]};
      sub_y = {1'b0, g_r};
    end else begin
      sub_x = {1'b0, v_r};
      sub_y = {1'b0, u_r};
    end
    sub_d      = sub_x - sub_y;
    sub_borrow = sub_d[W];
  end

  assign start_ready = (state_r == ST_IDLE);
  assign res_valid   = (state_r == ST_DONE);
  assign gcd_value   = g_r;
  assign lcm_value   = lcm_r;
  assign error_flag  = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start_valid) begin
            a_r <= first_value;
            b_r <= second_value;
            u_r <= first_value;
            v_r <= second_value;
            k_r <= '0;
            if (first_value == '0 || second_value == '0) begin
              err_r   <= 1'b1;
              g_r     <= '0;
              lcm_r   <= '0;
              state_r <= ST_DONE;
            end else begin
              err_r   <= 1'b0;
              state_r <= ST_GCD;
            end
          end
        end
        ST_GCD: begin
          priority if (v_r == '0) begin
            g_r     <= u_r << k_r;
            rem_r   <= '0;
            quo_r   <= a_r;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end else if (!u_r[0] && !v_r[0]) begin
            u_r <= u_r >> 1;
            v_r <= v_r >> 1;
            k_r <= k_r + 1'b1;
          end else if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (sub_borrow) begin
            // keep u as the smaller odd value
            u_r <= v_r;
            v_r <= u_r;
          end else begin
            v_r <= sub_d[W-1:0];
          end
        end
        ST_DIV: begin
          if (sub_borrow) begin
            rem_r <= sub_x[W-1:0];
            quo_r <= {quo_r[W-2:0], 1'b0};
          end else begin
            rem_r <= sub_d[W-1:0];
            quo_r <= {quo_r[W-2:0], 1'b1};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(W - 1)) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          lcm_r   <= (2*W)'(quo_r) * (2*W)'(b_r);
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule : gls_engine

>>> rtl/core/gcd_lcm_subtractive_unit.sv
// Top level of the GCD / LCM unit: engine plus registered result channel.
// Steps: binary GCD (shift, swap or subtract), W = OPERAND_WIDTH restoring divide steps, then one multiply;
// a zero operand skips these and gives an error result with zero GCD and LCM.
// Throughput: one item at a time; the shared subtractor serves GCD then W divide steps.
// The next item is taken once the engine hands its result to the output register.
// Reset (rst_n, synchronous, active low) clears the sequencer and the output valid.
module gcd_lcm_subtractive_unit #(
  parameter int unsigned OPERAND_WIDTH = gls_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OPERAND_WIDTH-1:0]   in_first_value,
  input  logic [OPERAND_WIDTH-1:0]   in_second_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [OPERAND_WIDTH-1:0]   out_gcd_value,
  output logic [2*OPERAND_WIDTH-1:0] out_lcm_value,
  output logic                       out_error_flag
);
  import gls_pkg::*;

  localparam int unsigned W = OPERAND_WIDTH;

  logic           res_valid;
  logic           res_ready;
  logic [W-1:0]   res_gcd;
  logic [2*W-1:0] res_lcm;
  logic           res_err;

  logic           out_valid_r;
  logic [W-1:0]   gcd_r;
  logic [2*W-1:0] lcm_r;
  logic           err_r;

  gls_engine #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_valid  (in_valid),
    .start_ready  (in_ready),
    .first_value  (in_first_value),
    .second_value (in_second_value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .gcd_value    (res_gcd),
    .lcm_value    (res_lcm),
    .error_flag   (res_err)
  );

  // Load when empty or when the waiting result transfers this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
        gcd_r       <= res_gcd;
        lcm_r       <= res_lcm;
        err_r       <= res_err;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_gcd_value  = gcd_r;
  assign out_lcm_value  = lcm_r;
  assign out_error_flag = err_r;

endmodule : gcd_lcm_subtractive_unit
